// ===== src/cube_cover_containment_filter_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef CUBE_COVER_CONTAINMENT_FILTER_UNIT_DEFINES_SVH
`define CUBE_COVER_CONTAINMENT_FILTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccf check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccf check failed");

`endif

// ===== src/ccf_pkg.sv =====
package ccf_pkg;

   localparam int MAX_CUBES = 64;
   localparam int NUM_VARS  = 32;
   localparam int LIT_W     = 32;
   localparam int CUBE_W    = 2 * LIT_W;
   localparam int IDX_W     = $clog2(MAX_CUBES);
   localparam int CNT_W     = $clog2(MAX_CUBES + 1);

   // variables at or above NUM_VARS are dropped on load
   localparam logic [LIT_W-1:0] VAR_MASK = LIT_W'((64'd1 << NUM_VARS) - 64'd1);

   // pos mask in the upper half, neg mask in the lower half
   typedef logic [CUBE_W-1:0] cube_type;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_FILTER = 3'b010,
      ST_DRAIN  = 3'b100
   } state_type;

   typedef struct packed {
      cube_type cube;
      logic     valid;
      logic     removed;
   } cell_state_type;

   // circulating copy of a cube; wrapped marks a token that came from a later cell
   typedef struct packed {
      cube_type cube;
      logic     valid;
      logic     wrapped;
   } tok_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             tok_load;
      logic             compare;
      logic             shift;
      logic             clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic head_live;
      logic rest_live;
   } chain_stat_type;

endpackage

// ===== src/ccf_if.sv =====
interface ccf_req_if import ccf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LIT_W-1:0] neg_literals;
   logic [LIT_W-1:0] pos_literals;
   logic             last_cube;

   modport source (output valid, output neg_literals, output pos_literals,
                   output last_cube, input ready);
   modport sink   (input valid, input neg_literals, input pos_literals,
                   input last_cube, output ready);
endinterface

interface ccf_rsp_if import ccf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LIT_W-1:0] out_neg_literals;
   logic [LIT_W-1:0] out_pos_literals;
   logic             out_last;
   logic             overflow;

   modport source (output valid, output out_neg_literals, output out_pos_literals,
                   output out_last, output overflow, input ready);
   modport sink   (input valid, input out_neg_literals, input out_pos_literals,
                   input out_last, input overflow, output ready);
endinterface

// ===== src/cube_cover_containment_filter_unit.sv =====
// Channel  Dir  Payload                                            Handshake
// req_ch   in   neg_literals, pos_literals, last_cube              valid/ready
// rsp_ch   out  out_neg_literals, out_pos_literals, out_last,      valid/ready
//               overflow
//
// Cubes load one per cycle into a row of MAX_CUBES cells. After the last cube
// the filter pass runs while copies rotate around the cell ring. Draining
// shifts every stored cube up to the final survivor through the head cell,
// removed cubes included, and waits while rsp_ch is stalled; req_ch is not ready
// from the last cube until the final survivor is taken. Synchronous reset clears the
// cell valid bits, the cube count and the overflow flag.
module cube_cover_containment_filter_unit import ccf_pkg::*; (
   input logic      clock,
   input logic      reset,
   ccf_req_if.sink  req_ch,
   ccf_rsp_if.source rsp_ch
);

   cell_ctrl_type  ctl;
   chain_stat_type stat;
   cell_state_type st  [MAX_CUBES];
   tok_type        tok [MAX_CUBES];
   logic [MAX_CUBES-1:0] live;
   cube_type       wr_cube;

   assign wr_cube = {req_ch.pos_literals & VAR_MASK, req_ch.neg_literals & VAR_MASK};

   ccf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_cube),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .overflow  (rsp_ch.overflow),
      .ctl       (ctl)
   );

   // cell row; token ring closes from the last cell back to cell 0
   for (genvar i = 0; i < MAX_CUBES; i++) begin : g_cell
      cell_state_type next_st;
      if (i == MAX_CUBES - 1) begin : g_tail
         assign next_st = '0;
      end else begin : g_mid
         assign next_st = st[i+1];
      end

      ccf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr_sel    (ctl.wr_en & (ctl.wr_idx == IDX_W'(i))),
         .wr_cube   (wr_cube),
         .next_st   (next_st),
         .prev_st   (st[(i + MAX_CUBES - 1) % MAX_CUBES]),
         .prev_tok  (tok[(i + MAX_CUBES - 1) % MAX_CUBES]),
         .ring_wrap (i == 0),
         .st        (st[i]),
         .tok       (tok[i])
      );

      assign live[i] = st[i].valid & ~st[i].removed;
   end

   assign stat.head_live = live[0];
   assign stat.rest_live = |live[MAX_CUBES-1:1];

   // head cell is the output register
   assign rsp_ch.out_neg_literals = st[0].cube[LIT_W-1:0];
   assign rsp_ch.out_pos_literals = st[0].cube[CUBE_W-1:LIT_W];
   assign rsp_ch.out_last         = ~stat.rest_live;

endmodule

// ===== src/ccf_cell.sv =====
module ccf_cell import ccf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctl,
   input  logic           wr_sel,
   input  cube_type       wr_cube,
   input  cell_state_type next_st,
   input  cell_state_type prev_st,
   input  tok_type        prev_tok,
   input  logic           ring_wrap,
   output cell_state_type st,
   output tok_type        tok
);

   cell_state_type st_ff, st_in;
   tok_type        tok_ff, tok_in;
   logic           eq, sub, hit;

   // passing token versus held cube
   always_comb begin
      eq  = (tok_ff.cube == st_ff.cube);
      sub = ((tok_ff.cube & ~st_ff.cube) == '0);
      // earlier identical copy, or a strictly smaller literal set
      hit = st_ff.valid & tok_ff.valid & ((eq & ~tok_ff.wrapped) | (sub & ~eq));
   end

   // held cube: clear, load, drain shift, removal
   always_comb begin
      st_in = st_ff;
      if (ctl.clear) begin
         st_in.valid   = 1'b0;
         st_in.removed = 1'b0;
      end else if (wr_sel) begin
         st_in.cube    = wr_cube;
         st_in.valid   = 1'b1;
         st_in.removed = 1'b0;
      end else if (ctl.shift) begin
         st_in = next_st;
      end else if (ctl.compare && hit) begin
         st_in.removed = 1'b1;
      end
   end

   // token ring: first load takes the neighbor's cube, then rotates
   always_comb begin
      tok_in = tok_ff;
      if (ctl.tok_load) begin
         tok_in.cube    = prev_st.cube;
         tok_in.valid   = prev_st.valid;
         tok_in.wrapped = ring_wrap;
      end else if (ctl.compare) begin
         tok_in.cube    = prev_tok.cube;
         tok_in.valid   = prev_tok.valid;
         tok_in.wrapped = prev_tok.wrapped | ring_wrap;
      end
   end

   // cube data and token run free; only the flags take reset
   always_ff @(posedge clock) begin
      tok_ff     <= tok_in;
      st_ff.cube <= st_in.cube;
      if (reset) begin
         st_ff.valid   <= 1'b0;
         st_ff.removed <= 1'b0;
      end else begin
         st_ff.valid   <= st_in.valid;
         st_ff.removed <= st_in.removed;
      end
   end

   assign st  = st_ff;
   assign tok = tok_ff;

endmodule

// ===== src/ccf_ctrl.sv =====
module ccf_ctrl import ccf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   input  logic           rsp_ready,
   input  chain_stat_type stat,
   output logic           req_ready,
   output logic           rsp_valid,
   output logic           overflow,
   output cell_ctrl_type  ctl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic             ovf_ff, ovf_in;
   logic             accept, full, finish;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN) & stat.head_live;
   assign overflow  = ovf_ff;
   assign accept    = req_valid & req_ready;
   assign full      = (count_ff == CNT_W'(MAX_CUBES));
   assign finish    = (state_ff == ST_DRAIN) & ~stat.rest_live &
                      (~stat.head_live | rsp_ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      ctl          = '0;
      ctl.wr_idx   = count_ff[IDX_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ctl.wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = ST_FILTER;
                  step_in  = '0;
               end
            end
         end
         ST_FILTER: begin
            ctl.tok_load = (step_ff == '0);
            ctl.compare  = (step_ff != '0);
            step_in      = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(MAX_CUBES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ctl.shift = ~stat.head_live | rsp_ready;
            if (finish) begin
               ctl.clear = 1'b1;
               state_in  = ST_LOAD;
               count_in  = '0;
               ovf_in    = 1'b0;
            end
         end
         default: begin
            state_in  = ST_LOAD;
            ctl.clear = 1'b1;
            count_in  = '0;
            ovf_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         step_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== src/ccf_checker.sv =====
`include "cube_cover_containment_filter_unit_defines.svh"

module ccf_checker import ccf_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [LIT_W-1:0] rsp_neg,
   input logic [LIT_W-1:0] rsp_pos,
   input logic             rsp_last,
   input logic             rsp_ovf
);

   logic [2*LIT_W+1:0] rsp_data;

   // whole result payload
   assign rsp_data = {rsp_neg, rsp_pos, rsp_last, rsp_ovf};

   // stalled result holds
   `CCF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // no new cubes while a cover drains
   `CCF_ASSERT_SAME(a_no_load_in_drain, rsp_valid, !req_ready)
   // last cube starts the filter pass
   `CCF_ASSERT_NEXT(a_last_blocks, req_valid && req_ready && req_last, !req_ready && !rsp_valid)
   // final survivor ends the cover
   `CCF_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last, !rsp_valid && req_ready)

endmodule

bind cube_cover_containment_filter_unit ccf_checker u_ccf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last_cube),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_neg   (rsp_ch.out_neg_literals),
   .rsp_pos   (rsp_ch.out_pos_literals),
   .rsp_last  (rsp_ch.out_last),
   .rsp_ovf   (rsp_ch.overflow)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import ccf_pkg::*;

   // one expected survivor of a cover
   typedef struct packed {
      logic [LIT_W-1:0] neg_lits;
      logic [LIT_W-1:0] pos_lits;
      logic             final_one;
      logic             overflowed;
   } survivor_type;

   // directed stimulus row; typed rows carry the one survivor they must produce
   typedef struct packed {
      logic [LIT_W-1:0] neg;
      logic [LIT_W-1:0] pos;
      logic             last;
      logic             typed;
      survivor_type     want;
   } stim_row_type;

   localparam int RANDOM_ITEMS = 380;
   localparam int IDLE_PCT     = 28;
   localparam int HOLD_CYCLES  = 400;
   localparam int DIRECTED_LEN = 17;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccf_req_if req_if ();
   ccf_rsp_if rsp_if ();

   cube_cover_containment_filter_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: cubes held for the open cover
   cube_type     held_cubes [$];
   logic         cover_overflow = 1'b0;
   survivor_type pending_survivors [$];
   survivor_type oldest_survivor;
   int           mismatch_count = 0;

   // traffic shaping; no_gaps is shared by both sides, the hold flags drive the result side only
   bit no_gaps    = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;

   stim_row_type directed_rows [DIRECTED_LEN] = '{
      // lone cube with every literal
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
      // lone empty cube
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}},
      // three identical cubes, first copy kept
      '{32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1, '{32'h1, 32'h8000_0000, 1'b1, 1'b0}},
      // plain containment
      '{32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 32'h0000_0004, 1'b0, 1'b0, '0},
      '{32'h0000_0003, 32'h0000_0004, 1'b1, 1'b0, '0},
      // empty cube in the middle wipes the rest
      '{32'h0000_0005, 32'h0000_0002, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h0000_0010, 32'h0000_0000, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}},
      // both polarities of one variable
      '{32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1, '{32'h1, 32'h0, 1'b1, 1'b0}},
      // alternating bits, last survivor is not the last cube
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, '0}
   };

   task automatic flag_mismatch(string what, logic [LIT_W-1:0] got, logic [LIT_W-1:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // fold one accepted cube into the cover; on the last cube, filter and
   // queue the survivors in load order unless the caller supplies them
   function automatic void absorb_cube(logic [LIT_W-1:0] neg, logic [LIT_W-1:0] pos,
                                       logic last, bit predict);
      cube_type     c;
      bit           gone [MAX_CUBES];
      bit           inner [MAX_CUBES];
      int           last_idx;
      survivor_type s;

      c = {pos & VAR_MASK, neg & VAR_MASK};
      if (held_cubes.size() < MAX_CUBES)
         held_cubes.push_back(c);
      else
         cover_overflow = 1'b1;
      if (!last)
         return;

      foreach (gone[i]) begin
         gone[i]  = 1'b0;
         inner[i] = 1'b0;
      end
      // identical cubes: later copies go
      for (int i = 0; i < held_cubes.size(); i++) begin
         if (!gone[i]) begin
            for (int j = i + 1; j < held_cubes.size(); j++)
               if (!gone[j] && held_cubes[j] == held_cubes[i])
                  gone[j] = 1'b1;
         end
      end
      // a cube with a strict subset among the rest is contained
      for (int i = 0; i < held_cubes.size(); i++) begin
         if (!gone[i]) begin
            for (int j = 0; j < held_cubes.size(); j++)
               if (j != i && !gone[j] && (held_cubes[j] & ~held_cubes[i]) == '0 &&
                   held_cubes[j] != held_cubes[i])
                  inner[i] = 1'b1;
         end
      end
      last_idx = -1;
      for (int i = 0; i < held_cubes.size(); i++)
         if (!gone[i] && !inner[i])
            last_idx = i;
      if (predict) begin
         for (int i = 0; i < held_cubes.size(); i++) begin
            if (!gone[i] && !inner[i]) begin
               s.neg_lits   = held_cubes[i][LIT_W-1:0];
               s.pos_lits   = held_cubes[i][CUBE_W-1:LIT_W];
               s.final_one  = (i == last_idx);
               s.overflowed = cover_overflow;
               pending_survivors.push_back(s);
            end
         end
      end
      held_cubes.delete();
      cover_overflow = 1'b0;
   endfunction

   // cube content: mostly a narrow pool so duplicates and containment occur
   function automatic void random_cube(output logic [LIT_W-1:0] neg,
                                       output logic [LIT_W-1:0] pos, input bit narrow);
      int mode;
      int sh;

      mode = $urandom_range(0, 9);
      if (narrow || mode < 5) begin
         sh  = $urandom_range(0, 1) ? 0 : 29;
         neg = LIT_W'($urandom_range(0, 7)) << sh;
         pos = LIT_W'($urandom_range(0, 7)) << sh;
      end else if (mode < 8) begin
         neg = $urandom & $urandom & $urandom;
         pos = $urandom & $urandom & $urandom;
      end else begin
         neg = $urandom;
         pos = $urandom;
      end
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_cube(logic [LIT_W-1:0] neg, logic [LIT_W-1:0] pos, logic last,
                             bit predict);
      while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.neg_literals <= neg;
      req_if.pos_literals <= pos;
      req_if.last_cube    <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      absorb_cube(neg, pos, last, predict);
      @(negedge clock);
   endtask

   // stimulus and end of run
   initial begin
      logic [LIT_W-1:0] neg;
      logic [LIT_W-1:0] pos;
      int               cover_idx;
      int               cover_len;
      int               items_sent;

      req_if.valid        = 1'b0;
      req_if.neg_literals = '0;
      req_if.pos_literals = '0;
      req_if.last_cube    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[r]) begin
         offer_cube(directed_rows[r].neg, directed_rows[r].pos, directed_rows[r].last,
                    !directed_rows[r].typed);
         if (directed_rows[r].typed)
            pending_survivors.push_back(directed_rows[r].want);
      end

      // random covers: a full store, two overflowing ones, the rest short
      cover_idx  = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS || cover_idx <= 14) begin
         case (cover_idx)
            3:       cover_len = MAX_CUBES;
            8:       cover_len = MAX_CUBES + 1;
            14:      cover_len = MAX_CUBES + 3;
            default: cover_len = $urandom_range(1, 10);
         endcase
         if (cover_idx == 3)
            hold_armed = 1'b1;
         no_gaps = (cover_idx >= 20 && cover_idx < 27);
         for (int n = 0; n < cover_len; n++) begin
            random_cube(neg, pos, cover_len >= MAX_CUBES);
            offer_cube(neg, pos, n == cover_len - 1, 1'b1);
         end
         items_sent += cover_len;
         cover_idx++;
      end
      req_if.valid <= 1'b0;

      while (pending_survivors.size() != 0)
         @(posedge clock);
      repeat (3 * MAX_CUBES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // result side ready, with one long hold-off armed when the full-store cover begins
   initial begin : rsp_ready_drive
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (no_gaps) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // compare each taken result with the oldest expected survivor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_survivors.size() == 0) begin
            flag_mismatch("unexpected result, neg", rsp_if.out_neg_literals, '0);
         end else begin
            oldest_survivor = pending_survivors.pop_front();
            if (rsp_if.out_neg_literals !== oldest_survivor.neg_lits)
               flag_mismatch("out_neg_literals", rsp_if.out_neg_literals,
                             oldest_survivor.neg_lits);
            if (rsp_if.out_pos_literals !== oldest_survivor.pos_lits)
               flag_mismatch("out_pos_literals", rsp_if.out_pos_literals,
                             oldest_survivor.pos_lits);
            if (rsp_if.out_last !== oldest_survivor.final_one)
               flag_mismatch("out_last", LIT_W'(rsp_if.out_last),
                             LIT_W'(oldest_survivor.final_one));
            if (rsp_if.overflow !== oldest_survivor.overflowed)
               flag_mismatch("overflow", LIT_W'(rsp_if.overflow),
                             LIT_W'(oldest_survivor.overflowed));
         end
      end
   end

   // hard stop
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
